[design/dvr_pkg.sv]
// Shared constants, types and helper functions of the duplicate vertex remap block.
package dvr_pkg;

    localparam int MAX_VERTICES  = 4096;
    localparam int CHANNEL_WIDTH = 32;
    localparam int NUM_CH        = 4;
    localparam int FIELD_W       = 32;
    localparam int KEY_W         = (CHANNEL_WIDTH < FIELD_W) ? CHANNEL_WIDTH : FIELD_W;
    localparam int IDX_W         = $clog2(MAX_VERTICES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int OUT_IDX_W     = 12;
    localparam int CFG_W         = 3;

    localparam logic [CFG_W-1:0] KEY_CH_RESET = CFG_W'(3);

    typedef logic [KEY_W-1:0]            key_t;
    typedef key_t [NUM_CH-1:0]           entry_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [OUT_IDX_W-1:0]        out_idx_t;
    typedef logic [CFG_W-1:0]            cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
        idx_t   rd_addr;
    } mem_req_t;

    // A count of zero compares one channel, anything above four compares four.
    function automatic logic [NUM_CH-1:0] channel_enable(input cfg_t kc);
        cfg_t              n;
        logic [NUM_CH-1:0] en;
        n = kc;
        if (kc == '0)
        begin
            n = CFG_W'(1);
        end
        else if (kc > CFG_W'(NUM_CH))
        begin
            n = CFG_W'(NUM_CH);
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            en[c] = (CFG_W'(c) < n);
        end
        return en;
    endfunction

endpackage

[design/dvr_if.sv]
// Valid/ready interfaces for the vertex input channel and the index output channel.
interface dvr_in_if;
    import dvr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mesh_start;
    logic signed [FIELD_W-1:0] key_ch0;
    logic signed [FIELD_W-1:0] key_ch1;
    logic signed [FIELD_W-1:0] key_ch2;
    logic signed [FIELD_W-1:0] key_ch3;

    modport source (output valid, mesh_start, key_ch0, key_ch1, key_ch2, key_ch3,
                    input ready);
    modport sink   (input valid, mesh_start, key_ch0, key_ch1, key_ch2, key_ch3,
                    output ready);
endinterface

interface dvr_out_if;
    import dvr_pkg::*;

    logic     valid;
    logic     ready;
    out_idx_t new_index;
    logic     duplicate_hit;
    logic     identity_so_far;
    logic     table_overflow;

    modport source (output valid, new_index, duplicate_hit, identity_so_far, table_overflow,
                    input ready);
    modport sink   (input valid, new_index, duplicate_hit, identity_so_far, table_overflow,
                    output ready);
endinterface

[design/dvr_key_mem.sv]
// Key table memory: one write port and one registered read port.
module dvr_key_mem (
    input  logic              clk,
    input  dvr_pkg::mem_req_t req,
    output dvr_pkg::entry_t   rd_data
);
    import dvr_pkg::*;

    entry_t mem [MAX_VERTICES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/dvr_search.sv]
// Search sequencer: scans the key table one entry a cycle through a shared comparator.
module dvr_search (
    input  logic              clk,
    input  logic              rst_n,
    input  dvr_pkg::cfg_t     key_channels,
    dvr_in_if.sink            vtx_in,
    dvr_out_if.source         idx_out,
    output dvr_pkg::mem_req_t mem_req,
    input  dvr_pkg::entry_t   rd_data
);
    import dvr_pkg::*;

    state_t   state_reg, state_next;
    entry_t   key_reg, key_next;
    cnt_t     cnt_reg, cnt_next;
    cnt_t     ord_reg, ord_next;
    logic     ident_reg, ident_next;
    idx_t     scan_reg, scan_next;
    logic     found_reg, found_next;

    logic     out_valid_reg, out_valid_next;
    out_idx_t out_index_reg, out_index_next;
    logic     out_dup_reg, out_dup_next;
    logic     out_ident_reg, out_ident_next;
    logic     out_ovf_reg, out_ovf_next;

    logic [NUM_CH-1:0] ch_en;
    logic              match;
    logic              scan_last;
    logic              out_free;
    entry_t            in_key;
    cnt_t              res_idx;
    logic              res_ident;

    assign in_key[0] = vtx_in.key_ch0[KEY_W-1:0];
    assign in_key[1] = vtx_in.key_ch1[KEY_W-1:0];
    assign in_key[2] = vtx_in.key_ch2[KEY_W-1:0];
    assign in_key[3] = vtx_in.key_ch3[KEY_W-1:0];

    // The comparator is the one shared unit: the stored entry against the held key.
    always_comb
    begin
        ch_en = channel_enable(key_channels);
        match = 1'b1;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (ch_en[c] && (rd_data[c] != key_reg[c]))
            begin
                match = 1'b0;
            end
        end
    end

    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) >= cnt_reg);
    assign out_free  = !out_valid_reg || idx_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ord_reg       <= '0;
            ident_reg     <= 1'b1;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ord_reg       <= ord_next;
            ident_reg     <= ident_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        out_index_reg <= out_index_next;
        out_dup_reg   <= out_dup_next;
        out_ident_reg <= out_ident_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        ord_next       = ord_reg;
        ident_next     = ident_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !idx_out.ready;
        out_index_next = out_index_reg;
        out_dup_next   = out_dup_reg;
        out_ident_next = out_ident_reg;
        out_ovf_next   = out_ovf_reg;
        res_idx        = CNT_W'(scan_reg);
        res_ident      = ident_reg;

        vtx_in.ready     = 1'b0;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = cnt_reg[IDX_W-1:0];
        mem_req.wr_data  = key_reg;
        // While scanning, the next entry is fetched as the current one is compared.
        mem_req.rd_addr  = (state_reg == ST_SEARCH) ? (scan_reg + IDX_W'(1)) : '0;

        case (state_reg)
            ST_IDLE:
            begin
                vtx_in.ready = 1'b1;
                if (vtx_in.valid)
                begin
                    key_next   = in_key;
                    scan_next  = '0;
                    found_next = 1'b0;
                    if (vtx_in.mesh_start)
                    begin
                        cnt_next   = '0;
                        ord_next   = '0;
                        ident_next = 1'b1;
                    end
                    if (vtx_in.mesh_start || (cnt_reg == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_dup_next = 1'b0;
                    out_ovf_next = 1'b0;
                    if (found_reg)
                    begin
                        res_idx      = CNT_W'(scan_reg);
                        out_dup_next = 1'b1;
                    end
                    else if (cnt_reg < CNT_W'(MAX_VERTICES))
                    begin
                        res_idx       = cnt_reg;
                        mem_req.wr_en = 1'b1;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_idx      = CNT_W'(MAX_VERTICES - 1);
                        out_ovf_next = 1'b1;
                    end
                    res_ident  = ident_reg && (res_idx == ord_reg);
                    ident_next = res_ident;
                    if (ord_reg < CNT_W'(MAX_VERTICES))
                    begin
                        ord_next = ord_reg + CNT_W'(1);
                    end
                    out_index_next = OUT_IDX_W'(res_idx);
                    out_ident_next = res_ident;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idx_out.valid           = out_valid_reg;
    assign idx_out.new_index       = out_index_reg;
    assign idx_out.duplicate_hit   = out_dup_reg;
    assign idx_out.identity_so_far = out_ident_reg;
    assign idx_out.table_overflow  = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("distinct count exceeds table depth");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (CNT_W'(scan_reg) < cnt_reg))
        else $error("scan pointer beyond filled entries");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    a_dup_ovf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_dup_reg && out_ovf_reg))
        else $error("duplicate and overflow flagged together");

endmodule

[design/duplicate_vertex_remap_core.sv]
// Top level of the duplicate vertex remap block: channel count register and datapath.
//
//   Channel   Direction  Handshake       Word
//   vtx_in    in         valid/ready     mesh_start, key_ch0..key_ch3
//   idx_out   out        valid/ready     new_index, duplicate_hit, identity_so_far,
//                                        table_overflow
//   cfg       in         cfg_we          cfg_wdata (key_channels)
//
// A vertex is taken when idle, searched unless its mesh is new, then sent out: the search
// stops at the first match or after all distinct keys of the mesh, one entry a cycle
// through the table's single read port. vtx_in is ready only between vertices.
// A finished word waits in the output register while the next vertex is taken; the
// result step stalls only if that register is still full. Reset clears the counters
// and flags; the key table needs no clearing, as only entries of the current mesh are read.
module duplicate_vertex_remap_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  dvr_pkg::cfg_t cfg_wdata,
    dvr_in_if.sink        vtx_in,
    dvr_out_if.source     idx_out
);
    import dvr_pkg::*;

    cfg_t     key_channels_reg;
    mem_req_t mem_req;
    entry_t   rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_channels_reg <= KEY_CH_RESET;
        end
        else if (cfg_we)
        begin
            key_channels_reg <= cfg_wdata;
        end
    end

    dvr_search u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_channels (key_channels_reg),
        .vtx_in       (vtx_in),
        .idx_out      (idx_out),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    dvr_key_mem u_key_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench of the duplicate vertex remap core: weld prediction on a scoreboard.
`timescale 1ns / 100ps

module tb;
    import dvr_pkg::*;

    typedef struct packed {
        out_idx_t new_index;
        logic     duplicate_hit;
        logic     identity_so_far;
        logic     table_overflow;
    } remap_word_t;

    // Predicts the remap word of each accepted vertex and checks the words that come out.
    class remap_scoreboard;
        entry_t      key_store[MAX_VERTICES];
        int          distinct_keys;
        int          ordinal;
        bit          identity;
        cfg_t        channels;
        remap_word_t expected_words[$];
        int          errors;
        int          words_seen;

        function new();
            distinct_keys = 0;
            ordinal       = 0;
            identity      = 1'b1;
            channels      = KEY_CH_RESET;
            errors        = 0;
            words_seen    = 0;
        endfunction

        function void set_channels(cfg_t value);
            channels = value;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        function void note_vertex(bit start, entry_t key);
            entry_t      cmask;
            int          n;
            int          hit;
            int          idx;
            remap_word_t w;
            if (start)
            begin
                distinct_keys = 0;
                ordinal       = 0;
                identity      = 1'b1;
            end
            n = (channels == '0) ? 1 : (channels > CFG_W'(NUM_CH)) ? NUM_CH : int'(channels);
            cmask = '0;
            for (int c = 0; c < n; c++)
            begin
                cmask[c] = '1;
            end
            hit = -1;
            for (int j = 0; j < distinct_keys; j++)
            begin
                if ((key_store[j] & cmask) == (key & cmask))
                begin
                    hit = j;
                    break;
                end
            end
            w = '0;
            if (hit >= 0)
            begin
                idx             = hit;
                w.duplicate_hit = 1'b1;
            end
            else if (distinct_keys < MAX_VERTICES)
            begin
                key_store[distinct_keys] = key;
                idx                      = distinct_keys;
                distinct_keys++;
            end
            else
            begin
                idx              = MAX_VERTICES - 1;
                w.table_overflow = 1'b1;
            end
            if (idx != ordinal)
            begin
                identity = 1'b0;
            end
            if (ordinal < MAX_VERTICES)
            begin
                ordinal++;
            end
            w.new_index       = out_idx_t'(idx);
            w.identity_so_far = identity;
            expected_words = {expected_words, w};
        endfunction

        task report(string msg);
            if (errors < 40)
            begin
                $display("error at word %0d: %s", words_seen, msg);
            end
            errors++;
        endtask

        task check_word(remap_word_t got);
            remap_word_t want;
            if (expected_words.size() == 0)
            begin
                report("word arrived with no vertex outstanding");
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.new_index !== want.new_index)
                begin
                    report($sformatf("new_index %0d, expected %0d",
                                     got.new_index, want.new_index));
                end
                if (got.duplicate_hit !== want.duplicate_hit)
                begin
                    report($sformatf("duplicate_hit %b, expected %b",
                                     got.duplicate_hit, want.duplicate_hit));
                end
                if (got.identity_so_far !== want.identity_so_far)
                begin
                    report($sformatf("identity_so_far %b, expected %b",
                                     got.identity_so_far, want.identity_so_far));
                end
                if (got.table_overflow !== want.table_overflow)
                begin
                    report($sformatf("table_overflow %b, expected %b",
                                     got.table_overflow, want.table_overflow));
                end
            end
            words_seen++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_t cfg_wdata;

    dvr_in_if  vtx_if();
    dvr_out_if idx_if();

    remap_scoreboard sb;
    remap_word_t     seen_word;
    int              sender_idle_pct    = 0;
    int              receiver_stall_pct = 0;
    entry_t          mesh_keys[$];
    int              mesh_target        = 0;
    int              reuse_pct          = 0;

    duplicate_vertex_remap_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vtx_in    (vtx_if),
        .idx_out   (idx_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        idx_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && idx_if.valid === 1'b1 && idx_if.ready === 1'b1)
        begin
            seen_word.new_index       = idx_if.new_index;
            seen_word.duplicate_hit   = idx_if.duplicate_hit;
            seen_word.identity_so_far = idx_if.identity_so_far;
            seen_word.table_overflow  = idx_if.table_overflow;
            sb.check_word(seen_word);
        end
    end

    function automatic entry_t make_key(logic [31:0] k0, logic [31:0] k1,
                                        logic [31:0] k2, logic [31:0] k3);
        return {k3, k2, k1, k0};
    endfunction

    function automatic logic [31:0] random_channel();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return {8'h00, 8'($urandom_range(0, 255)), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    // Keys already seen in this mesh (reuse_pct percent), some with one channel altered, the rest fresh.
    function automatic entry_t pick_key();
        entry_t k;
        int     r;
        r = $urandom_range(99);
        if (mesh_keys.size() != 0 && r < reuse_pct)
        begin
            return mesh_keys[$urandom_range(mesh_keys.size() - 1)];
        end
        if (mesh_keys.size() != 0 && r < reuse_pct + 15)
        begin
            k = mesh_keys[$urandom_range(mesh_keys.size() - 1)];
            k[2'($urandom_range(NUM_CH - 1))] = random_channel();
            return k;
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            k[c] = random_channel();
        end
        return k;
    endfunction

    task automatic send_vertex(input bit start, input entry_t key);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            vtx_if.valid <= 1'b0;
            @(posedge clk);
        end
        vtx_if.valid      <= 1'b1;
        vtx_if.mesh_start <= start;
        vtx_if.key_ch0    <= key[0];
        vtx_if.key_ch1    <= key[1];
        vtx_if.key_ch2    <= key[2];
        vtx_if.key_ch3    <= key[3];
        @(posedge clk);
        while (vtx_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.note_vertex(start, key);
    endtask

    // Always waits for a clock edge, so valid is never lowered and raised in one step.
    task automatic drain_words();
        vtx_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_key_channels(input cfg_t value);
        drain_words();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_channels(value);
    endtask

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        bit     start;
        entry_t key;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            start = 1'b0;
            if (mesh_keys.size() >= mesh_target || $urandom_range(99) == 0)
            begin
                start = 1'b1;
                mesh_keys.delete();
                mesh_target = $urandom_range(1, 60);
                case ($urandom_range(2))
                    0: reuse_pct = 0;
                    1: reuse_pct = 30;
                    default: reuse_pct = 70;
                endcase
            end
            if ($urandom_range(99) < 2)
            begin
                drain_words();
            end
            key = pick_key();
            mesh_keys = {mesh_keys, key};
            send_vertex(start, key);
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= KEY_CH_RESET;
        vtx_if.valid      <= 1'b0;
        vtx_if.mesh_start <= 1'b0;
        vtx_if.key_ch0    <= '0;
        vtx_if.key_ch1    <= '0;
        vtx_if.key_ch2    <= '0;
        vtx_if.key_ch3    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset channel count of three; the first vertex carries no mesh start.
        send_vertex(1'b0, make_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_key(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
        send_vertex(1'b0, make_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
        send_vertex(1'b1, make_key(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
        send_vertex(1'b0, make_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_vertex(1'b0, make_key(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000));

        // The mesh carries on across the changes of channel count to four and to zero.
        set_key_channels(CFG_W'(4));
        send_vertex(1'b0, make_key(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h1234_5678));
        send_vertex(1'b0, make_key(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
        set_key_channels(CFG_W'(0));
        send_vertex(1'b0, make_key(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_key(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004));
        set_key_channels(CFG_W'(7));
        send_vertex(1'b1, make_key(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_vertex(1'b0, make_key(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
        send_vertex(1'b0, make_key(32'h0002_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_vertex(1'b0, make_key(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
        send_vertex(1'b0, make_key(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        send_vertex(1'b1, make_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_vertex(1'b1, make_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

        set_key_channels(CFG_W'(2));
        random_phase(150, 0, 0);
        set_key_channels(CFG_W'(4));
        random_phase(150, 88, 0);
        set_key_channels(CFG_W'(1));
        random_phase(150, 0, 88);
        set_key_channels(CFG_W'(6));
        random_phase(150, 28, 28);
        set_key_channels(CFG_W'(3));
        random_phase(150, 0, 0);

        drain_words();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
